FILE: rtl/core/capture_period_average_speed_top_defines.svh
// ----------------------------------------------------------------------------
// capture_period_average_speed_top_defines.svh
// Assertion macros used by the checker of the capture tachometer block.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_AVERAGE_SPEED_TOP_DEFINES_SVH
`define CAPTURE_PERIOD_AVERAGE_SPEED_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cpas_pkg.sv
// ----------------------------------------------------------------------------
// cpas_pkg
// Fixed widths and reset constants of the capture tachometer block.
// ----------------------------------------------------------------------------
package cpas_pkg;

    // Width of the reported average period.
    localparam int AVG_W = 16;

    // Width of the tick rate register and of the speed result (Q24.8).
    localparam int RATE_W = 32;

    // Tick rate after reset: 39062.5 Hz in Q24.8.
    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 32'd10000000;

endpackage

FILE: rtl/core/cpas_div.sv
// ----------------------------------------------------------------------------
// cpas_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpas_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    // Step counter and the done pulse after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/capture_period_average_speed_top.sv
// ----------------------------------------------------------------------------
// capture_period_average_speed_top
// Tachometer that averages input-capture periods and converts them to speed.
// ----------------------------------------------------------------------------
// Each accepted item is a timer stamp; the period since the previous stamp
// (zero after reset) is formed modulo 2^STAMP_BITS and added to a running sum
// bit-serially over SUM_W = STAMP_BITS + clog2(WINDOW) bits; no new item is
// taken until the sum is done. Every WINDOW-th item then drives the shared
// bit-serial divider twice, first for sum / WINDOW and then for tick_rate_q8 /
// average, with a dividend width of DVD_W = max(SUM_W, 32), and the input
// opens again when that item's result is registered.
// A zero average yields a saturated speed and a set divide_fault.
// The result waits in an output register; the next item is accepted while it
// waits, and only the next result stalls until it has been taken.
// ----------------------------------------------------------------------------
module capture_period_average_speed_top #(
    parameter int WINDOW     = 16,
    parameter int STAMP_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cpas_pkg::RATE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [STAMP_BITS-1:0]        i_capture_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cpas_pkg::AVG_W-1:0]   o_average_period,
    output logic [cpas_pkg::RATE_W-1:0]  o_speed_q8,
    output logic                         o_divide_fault
);

    import cpas_pkg::*;

    localparam int SUM_W = STAMP_BITS + $clog2(WINDOW);
    localparam int BIT_W = $clog2(SUM_W);
    localparam int CNT_W = $clog2(WINDOW);
    localparam int DVD_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int WIN_W = $clog2(WINDOW + 1);
    localparam int DVS_W = (STAMP_BITS > WIN_W) ? STAMP_BITS : WIN_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ACC     = 3'd1;
    localparam logic [2:0] ST_DIV_AVG = 3'd2;
    localparam logic [2:0] ST_DIV_SPD = 3'd3;
    localparam logic [2:0] ST_LOAD    = 3'd4;

    logic [2:0]            r_state;
    logic [RATE_W-1:0]     r_tick_rate;
    logic [STAMP_BITS-1:0] r_prev;
    logic [SUM_W-1:0]      r_sum_sh;
    logic                  r_borrow;
    logic                  r_carry;
    logic [BIT_W-1:0]      r_bit;
    logic [CNT_W-1:0]      r_count;
    logic                  r_div_start;
    logic                  r_out_valid;

    logic [STAMP_BITS-1:0] r_a_sh;
    logic [STAMP_BITS-1:0] r_b_sh;
    logic [STAMP_BITS-1:0] r_avg;
    logic [RATE_W-1:0]     r_spd;
    logic [AVG_W-1:0]      r_out_avg;
    logic [RATE_W-1:0]     r_out_spd;
    logic                  r_out_fault;

    logic                  in_accept;
    logic                  out_free;
    logic                  in_range;
    logic                  a_bit;
    logic                  b_bit;
    logic                  diff_bit;
    logic                  n_borrow;
    logic                  per_bit;
    logic                  sum_bit;
    logic                  n_carry;
    logic                  last_bit;
    logic                  avg_zero;

    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quotient;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_bit  = (r_bit == BIT_W'(SUM_W - 1));
    assign avg_zero  = (r_avg == '0);

    // Serial subtract of the previous stamp and serial add into the sum.
    // Above the stamp width the period is masked to zero.
    always_comb begin
        a_bit    = r_a_sh[0];
        b_bit    = r_b_sh[0];
        in_range = (r_bit < BIT_W'(STAMP_BITS));
        diff_bit = a_bit ^ b_bit ^ r_borrow;
        n_borrow = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & r_borrow);
        per_bit  = in_range & diff_bit;
        sum_bit  = r_sum_sh[0] ^ per_bit ^ r_carry;
        n_carry  = (r_sum_sh[0] & per_bit) | (r_carry & (r_sum_sh[0] ^ per_bit));
    end

    // The shared divider first averages the sum, then divides the tick rate.
    always_comb begin
        if (r_state == ST_DIV_AVG) begin
            div_dividend = DVD_W'(r_sum_sh);
            div_divisor  = DVS_W'(WINDOW);
        end else begin
            div_dividend = DVD_W'(r_tick_rate);
            div_divisor  = DVS_W'(r_avg);
        end
    end

    cpas_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Sequencer, accumulator state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick_rate <= TICK_RATE_RESET;
            r_prev      <= '0;
            r_sum_sh    <= '0;
            r_borrow    <= 1'b0;
            r_carry     <= 1'b0;
            r_bit       <= '0;
            r_count     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A divide starts after the last sum bit of a window and after the average.
            r_div_start <= ((r_state == ST_ACC) && last_bit &&
                            (r_count == CNT_W'(WINDOW - 1))) ||
                           ((r_state == ST_DIV_AVG) && div_done);
            if (i_cfg_we) begin
                r_tick_rate <= i_cfg_data;
            end
            // The output register fills from the load state and empties when taken.
            if (r_state == ST_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_prev   <= i_capture_stamp;
                        r_borrow <= 1'b0;
                        r_carry  <= 1'b0;
                        r_bit    <= '0;
                        r_state  <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_sum_sh <= {sum_bit, r_sum_sh[SUM_W-1:1]};
                    r_borrow <= n_borrow;
                    r_carry  <= n_carry;
                    r_bit    <= r_bit + BIT_W'(1);
                    if (last_bit) begin
                        if (r_count == CNT_W'(WINDOW - 1)) begin
                            r_count <= '0;
                            r_state <= ST_DIV_AVG;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_DIV_AVG: begin
                    // The divider has taken the sum, so the next window starts clean.
                    if (r_div_start) begin
                        r_sum_sh <= '0;
                    end
                    if (div_done) begin
                        r_state <= ST_DIV_SPD;
                    end
                end
                ST_DIV_SPD: begin
                    if (div_done) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath shift registers, quotients and the output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_accept) begin
            r_a_sh <= i_capture_stamp;
            r_b_sh <= r_prev;
        end else if (r_state == ST_ACC) begin
            r_a_sh <= {1'b0, r_a_sh[STAMP_BITS-1:1]};
            r_b_sh <= {1'b0, r_b_sh[STAMP_BITS-1:1]};
        end
        if (r_state == ST_DIV_AVG && div_done) begin
            r_avg <= div_quotient[STAMP_BITS-1:0];
        end
        if (r_state == ST_DIV_SPD && div_done) begin
            r_spd <= div_quotient[RATE_W-1:0];
        end
        if (r_state == ST_LOAD && out_free) begin
            r_out_avg   <= AVG_W'(r_avg);
            r_out_spd   <= avg_zero ? '1 : r_spd;
            r_out_fault <= avg_zero;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_average_period = r_out_avg;
    assign o_speed_q8       = r_out_spd;
    assign o_divide_fault   = r_out_fault;

endmodule

FILE: rtl/core/cpas_chk.sv
// ----------------------------------------------------------------------------
// cpas_chk
// Port-level checker for the capture tachometer block, bound to its top level.
// ----------------------------------------------------------------------------
`include "capture_period_average_speed_top_defines.svh"

module cpas_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [cpas_pkg::AVG_W-1:0]  o_average_period,
    input logic [cpas_pkg::RATE_W-1:0] o_speed_q8,
    input logic                        o_divide_fault
);

    import cpas_pkg::*;

    // A waiting result keeps its value until it is taken.
    `CPAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_average_period) && $stable(o_speed_q8) && $stable(o_divide_fault), "result changed while waiting")

    // A fault is only reported for a zero average.
    `CPAS_ASSERT_NOW(a_fault_avg, i_clk, i_rst_n, o_out_valid && o_divide_fault, o_average_period == '0, "fault with nonzero average")

    // A fault always comes with a saturated speed.
    `CPAS_ASSERT_NOW(a_fault_speed, i_clk, i_rst_n, o_out_valid && o_divide_fault, o_speed_q8 == {RATE_W{1'b1}}, "fault without saturated speed")

    // An accepted item occupies the serial accumulator in the next cycle.
    `CPAS_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready stayed high after an item")

endmodule

bind capture_period_average_speed_top cpas_chk u_cpas_chk (.*);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capture-period averaging tachometer.
// ----------------------------------------------------------------------------
// A small table of full windows comes first: zero periods from the reset
// stamp, then full-scale wrapping periods. Its closing results are typed in.
// Random windows of differently shaped periods follow. They run under several
// tick rates, the register extremes among them, and under four idling
// patterns on the two handshakes. The random results are checked against an in-bench
// model of the period sum, the mean and the speed divide.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpas_pkg::*;

    localparam int WINDOW            = 16;
    localparam int STAMP_W           = 16;
    localparam int SUM_W             = 20;
    localparam int PHASES            = 7;
    localparam int WINDOWS_PER_PHASE = 4;
    localparam int DRAIN_CYCLES      = 120;
    localparam int HOLD_CYCLES       = 1500;
    localparam int LIMIT_CYCLES      = 400000;

    typedef struct packed {
        logic [AVG_W-1:0]  average_period;
        logic [RATE_W-1:0] speed_q8;
        logic              divide_fault;
    } t_speed_result;

    typedef struct packed {
        logic [STAMP_W-1:0] period;
        logic               typed;
        t_speed_result      result;
    } t_window_row;

    // Shapes of the periods inside one random window.
    typedef enum int {
        SHAPE_ANY,
        SHAPE_STILL,
        SHAPE_FULL,
        SHAPE_MID,
        SHAPE_CRAWL
    } t_period_shape;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [RATE_W-1:0]    i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [STAMP_W-1:0]   i_capture_stamp = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [AVG_W-1:0]     o_average_period;
    logic [RATE_W-1:0]    o_speed_q8;
    logic                 o_divide_fault;

    // Copy of the block state kept by the bench.
    logic [STAMP_W-1:0]   last_stamp   = '0;
    logic [SUM_W-1:0]     period_acc   = '0;
    int                   periods_seen = 0;
    logic [RATE_W-1:0]    rate_q8      = TICK_RATE_RESET;

    t_speed_result        speed_expected[$];

    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_requests  = 0;
    int                   holds_served   = 0;
    int                   hold_left      = 0;
    int                   items_sent     = 0;
    int                   results_seen   = 0;
    int                   mismatches     = 0;
    int                   cycles         = 0;

    // Typed expectations: rate is the reset value, 10000000 / 65535 = 152.
    t_window_row directed_plan[2] = '{
        '{16'h0000, 1'b1, '{16'h0000, 32'hFFFF_FFFF, 1'b1}},
        '{16'hFFFF, 1'b1, '{16'hFFFF, 32'd152,       1'b0}}
    };

    logic [RATE_W-1:0] rate_plan[PHASES] = '{
        32'hFFFF_FFFF, 32'd1, 32'd0, 32'h8000_0000, 32'd0, TICK_RATE_RESET, 32'd2
    };
    int send_idle_plan[4]  = '{0, 68, 0, 18};
    int recv_stall_plan[4] = '{0, 0, 68, 18};

    capture_period_average_speed_top #(
        .WINDOW     (WINDOW),
        .STAMP_BITS (STAMP_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_capture_stamp  (i_capture_stamp),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_average_period (o_average_period),
        .o_speed_q8       (o_speed_q8),
        .o_divide_fault   (o_divide_fault)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit well above the slowest legal run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycles, speed_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Adds one stamp to the period sum and closes the window when it is full.
    function automatic bit accumulate_period(input logic [STAMP_W-1:0] stamp,
                                             output t_speed_result res);
        logic [STAMP_W-1:0] period;
        logic [SUM_W-1:0]   mean;
        period       = stamp - last_stamp;
        last_stamp   = stamp;
        period_acc   = period_acc + SUM_W'(period);
        periods_seen = periods_seen + 1;
        res          = '0;
        if (periods_seen < WINDOW) begin
            return 1'b0;
        end
        mean               = period_acc / SUM_W'(WINDOW);
        res.average_period = mean[AVG_W-1:0];
        if (mean == '0) begin
            // A zero mean saturates the speed and flags the divide.
            res.speed_q8     = '1;
            res.divide_fault = 1'b1;
        end else begin
            res.speed_q8     = rate_q8 / RATE_W'(mean);
            res.divide_fault = 1'b0;
        end
        period_acc   = '0;
        periods_seen = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, cycle %0d)",
                 what, got, want, results_seen, cycles);
        mismatches++;
    endtask

    // Offers one stamp, with random idle cycles ahead of it, until accepted.
    task automatic send_stamp(input logic [STAMP_W-1:0] stamp, input bit typed,
                              input t_speed_result typed_res);
        t_speed_result predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_capture_stamp = stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (accumulate_period(stamp, predicted)) begin
            speed_expected.push_back(typed ? typed_res : predicted);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_empty();
        i_in_valid = 1'b0;
        while (speed_expected.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Idle the input, collect every result, then let the block settle.
    task automatic wait_drained();
        hold_until_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_tick_rate(input logic [RATE_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        rate_q8    = value;
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_speed_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (speed_expected.size() == 0) begin
                report_mismatch("result with none expected", o_speed_q8, '0);
            end else begin
                want = speed_expected.pop_front();
                if (o_average_period !== want.average_period) begin
                    report_mismatch("average_period", 32'(o_average_period),
                                    32'(want.average_period));
                end
                if (o_speed_q8 !== want.speed_q8) begin
                    report_mismatch("speed_q8", o_speed_q8, want.speed_q8);
                end
                if (o_divide_fault !== want.divide_fault) begin
                    report_mismatch("divide_fault", 32'(o_divide_fault),
                                    32'(want.divide_fault));
                end
            end
        end
    end

    initial begin
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] period;
        t_period_shape      shape;
        t_speed_result      no_result;
        stamp     = '0;
        period    = '0;
        no_result = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed windows at the reset tick rate.
        foreach (directed_plan[w]) begin
            for (int i = 0; i < WINDOW; i++) begin
                stamp = stamp + directed_plan[w].period;
                send_stamp(stamp, directed_plan[w].typed && (i == WINDOW - 1),
                           directed_plan[w].result);
            end
        end

        // Random windows, one tick rate and one idling pattern per phase.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_tick_rate((p == 4) ? RATE_W'($urandom) : rate_plan[p]);
            send_idle_pct  = send_idle_plan[p % 4];
            recv_stall_pct = recv_stall_plan[p % 4];
            if (p == 0) begin
                hold_requests++;
            end
            for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
                if (p == 2 && w == 2) begin
                    hold_until_empty();
                end
                shape = t_period_shape'($urandom_range(4));
                for (int i = 0; i < WINDOW; i++) begin
                    case (shape)
                        SHAPE_ANY:   period = STAMP_W'($urandom_range(16'hFFFF));
                        SHAPE_STILL: period = STAMP_W'($urandom_range(1));
                        SHAPE_FULL:  period = STAMP_W'($urandom_range(16'hFFFF, 16'hFE00));
                        SHAPE_MID:   period = STAMP_W'($urandom_range(4000, 1));
                        default:     period = STAMP_W'($urandom_range(40));
                    endcase
                    stamp = stamp + period;
                    send_stamp(stamp, 1'b0, no_result);
                end
            end
        end

        wait_drained();

        $display("Sent %0d capture stamps over %0d tick rates and four idling patterns.",
                 items_sent, PHASES + 1);
        $display("Checked %0d speed results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && speed_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
